// ===== hdl/glzw_pkg.sv =====
// Shared constants, types and helper functions for the GIF LZW encoder.
package glzw_pkg;

  localparam int HASH_SIZE  = 5003;
  localparam int HADDR_W    = $clog2(HASH_SIZE);
  localparam int MAX_BITS   = 12;
  localparam int CODE_LIMIT = 4096;
  localparam int KEY_W      = 20;
  localparam int ENTRY_W    = MAX_BITS + 1 + KEY_W;
  localparam int ACC_W      = 24;

  function automatic int calc_shift();
    int f;
    int n;
    f = HASH_SIZE;
    n = 0;
    while (f < 65536) begin
      f = f * 2;
      n = n + 1;
    end
    return (n <= 8) ? 8 - n : 0;
  endfunction

  localparam int HASH_SHIFT = calc_shift();

  localparam logic [1:0] CS_PREFIX = 2'd0;
  localparam logic [1:0] CS_CLEAR  = 2'd1;
  localparam logic [1:0] CS_EOI    = 2'd2;

  typedef struct packed {
    logic       accept;
    logic       start;
    logic       hash_rd;
    logic       probe_rd;
    logic       hit_take;
    logic       put;
    logic [1:0] code_sel;
    logic       put_eof;
    logic       emit;
    logic       miss_upd;
    logic       tbl_write;
    logic       tbl_full;
    logic       flush;
    logic       clr_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic miss_end;
    logic emit_more;
    logic can_emit;
    logic pend_valid;
    logic nfc_full;
    logic last;
    logic clr_last;
  } dp_sts_t;

  function automatic logic [3:0] eff_min(input logic [3:0] m);
    logic [3:0] r;
    r = m;
    if (m < 4'd2) r = 4'd2;
    if (m > 4'd8) r = 4'd8;
    return r;
  endfunction

endpackage

// ===== hdl/gif_lzw_encoder.sv =====
// Top level of the GIF LZW encoder: configuration register, controller and datapath.
//
// The in_ channel takes one pixel index per word (tdata) with tlast on the last
// pixel of the image. The out_ channel returns the packed code stream one byte per
// word; tlast marks the last byte caused by an input word and tuser marks the final
// byte of the image. The cfg_ channel writes min_code_size and is always ready;
// write it only while the block is idle.
// One pixel is taken at a time. A dictionary hit passes through accept, hash
// read, compare, and a wrap-up in the tail and done states. Each collision probe adds
// a further read and compare through the single read port of the hash table. A miss
// adds writing out the prefix code; every further code written (clear code, final
// code or end code) and each byte produced add to the time taken by that pixel.
// The first pixel of an image, and a pixel that fills the dictionary, start a
// clearing pass over the 5003-entry table at the end of that pixel, during which
// no pixel is accepted.
// Reset puts min_code_size at 8 and waits for the first pixel of a new image.
// When the receiver stalls, one finished byte sits in the output register and one
// more in a holding stage, after which the controller waits.
module gif_lzw_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // pixel[7:0]
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte[7:0]
  output logic       out_tlast,
  output logic [0:0] out_tuser,  // end_of_stream[0]
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data
);

  logic [3:0]        mcs_r;
  glzw_pkg::dp_cmd_t cmd;
  glzw_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcs_r <= 4'd8;
    end else if (cfg_valid) begin
      mcs_r <= cfg_data;
    end
  end

  glzw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  glzw_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .min_code_size (mcs_r),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

// ===== hdl/glzw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module glzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/glzw_dp.sv =====
// Datapath of the LZW encoder: hash table, code state, bit packer and output stage.
module glzw_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [3:0]        min_code_size,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [7:0]        out_tdata,
  output logic              out_tlast,
  output logic [0:0]        out_tuser,
  input  glzw_pkg::dp_cmd_t cmd,
  output glzw_pkg::dp_sts_t sts
);

  localparam int AW = glzw_pkg::HADDR_W;
  localparam logic [AW-1:0] HS = AW'(glzw_pkg::HASH_SIZE);

  logic [3:0]  m;
  logic [12:0] cc;
  logic [7:0]  px_mask;

  logic [7:0]  px_r;
  logic        last_r;
  logic [11:0] prefix_r, prefix_nxt;
  logic [12:0] nfc_r, nfc_nxt;
  logic [3:0]  width_r, width_nxt;
  logic        cp_r, cp_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [4:0]  bc_r, bc_nxt;
  logic        eof_r, eof_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] disp_r, disp_nxt;
  logic [AW-1:0] tries_r, tries_nxt;
  logic        probing_r, probing_nxt;
  logic [AW-1:0] clr_addr_r;
  logic        pend_valid_r, pend_valid_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_eos_r, out_eos_nxt;

  logic [AW:0]   hv;
  logic [AW-1:0] hidx;
  logic [AW-1:0] dsel;
  logic [AW:0]   wrap_sum;
  logic [AW-1:0] i_step;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [glzw_pkg::ENTRY_W-1:0] ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [glzw_pkg::ENTRY_W-1:0] ram_rdata;

  logic [19:0] key;
  logic        s_valid;
  logic [19:0] s_key;
  logic [11:0] s_code;
  logic        out_free;
  logic [11:0] put_code;
  logic [23:0] keep;
  logic [12:0] maxcode;

  assign m       = glzw_pkg::eff_min(min_code_size);
  assign cc      = 13'd1 << m;
  assign px_mask = 8'(cc - 13'd1);
  assign key     = {px_r, prefix_r};
  assign s_code  = ram_rdata[glzw_pkg::ENTRY_W-1 -: 12];
  assign s_valid = ram_rdata[glzw_pkg::KEY_W];
  assign s_key   = ram_rdata[glzw_pkg::KEY_W-1:0];

  assign hv   = (AW+1)'((16'(px_r) << glzw_pkg::HASH_SHIFT) ^ 16'(prefix_r));
  assign hidx = (hv >= (AW+1)'(glzw_pkg::HASH_SIZE)) ?
                AW'(hv - (AW+1)'(glzw_pkg::HASH_SIZE)) : AW'(hv);

  assign dsel     = probing_r ? disp_r : ((i_r == '0) ? AW'(1) : HS - i_r);
  assign wrap_sum = {1'b0, i_r} + (AW+1)'(glzw_pkg::HASH_SIZE) - {1'b0, dsel};
  assign i_step   = (i_r >= dsel) ? i_r - dsel : wrap_sum[AW-1:0];

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    unique case (cmd.code_sel)
      glzw_pkg::CS_PREFIX: put_code = prefix_r;
      glzw_pkg::CS_CLEAR:  put_code = cc[11:0];
      glzw_pkg::CS_EOI:    put_code = 12'(cc + 13'd1);
      default:             put_code = prefix_r;
    endcase
    keep    = (bc_r >= 5'd24) ? 24'hFFFFFF : ((24'd1 << bc_r) - 24'd1);
    maxcode = (width_r >= 4'(glzw_pkg::MAX_BITS)) ? 13'(glzw_pkg::CODE_LIMIT) :
              ((13'd1 << width_r) - 13'd1);
  end

  always_comb begin
    prefix_nxt     = prefix_r;
    nfc_nxt        = nfc_r;
    width_nxt      = width_r;
    cp_nxt         = cp_r;
    acc_nxt        = acc_r;
    bc_nxt         = bc_r;
    eof_nxt        = eof_r;
    i_nxt          = i_r;
    disp_nxt       = disp_r;
    tries_nxt      = tries_r;
    probing_nxt    = probing_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_tready ? 1'b0 : out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_eos_nxt    = out_eos_r;
    ram_we         = 1'b0;
    ram_waddr      = i_r;
    ram_wdata      = {nfc_r[11:0], 1'b1, key};
    ram_re         = 1'b0;
    ram_raddr      = hidx;

    if (cmd.start) begin
      width_nxt  = m + 4'd1;
      nfc_nxt    = cc + 13'd2;
      cp_nxt     = 1'b0;
      acc_nxt    = '0;
      bc_nxt     = '0;
      eof_nxt    = 1'b0;
      prefix_nxt = {4'd0, in_tdata & px_mask};
    end
    if (cmd.hash_rd) begin
      ram_re      = 1'b1;
      ram_raddr   = hidx;
      i_nxt       = hidx;
      probing_nxt = 1'b0;
    end
    if (cmd.probe_rd) begin
      ram_re      = 1'b1;
      ram_raddr   = i_step;
      i_nxt       = i_step;
      disp_nxt    = dsel;
      tries_nxt   = probing_r ? tries_r + AW'(1) : '0;
      probing_nxt = 1'b1;
    end
    if (cmd.hit_take) begin
      prefix_nxt = s_code;
    end
    if (cmd.put) begin
      acc_nxt = (acc_r & keep) | (24'(put_code) << bc_r[3:0]);
      bc_nxt  = bc_r + 5'(width_r);
      eof_nxt = cmd.put_eof;
      if (cp_r) begin
        width_nxt = m + 4'd1;
        cp_nxt    = 1'b0;
      end else if (nfc_r > maxcode && width_r < 4'(glzw_pkg::MAX_BITS)) begin
        width_nxt = width_r + 4'd1;
      end
    end
    if (cmd.emit) begin
      acc_nxt = acc_r >> 8;
      bc_nxt  = (bc_r >= 5'd8) ? bc_r - 5'd8 : 5'd0;
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = pend_r;
        out_last_nxt  = 1'b0;
        out_eos_nxt   = 1'b0;
      end
      pend_valid_nxt = 1'b1;
      pend_nxt       = acc_r[7:0];
    end
    if (cmd.miss_upd) begin
      prefix_nxt = {4'd0, px_r};
    end
    if (cmd.tbl_write) begin
      ram_we  = 1'b1;
      nfc_nxt = nfc_r + 13'd1;
    end
    if (cmd.tbl_full) begin
      nfc_nxt = cc + 13'd2;
      cp_nxt  = 1'b1;
    end
    if (cmd.flush) begin
      out_valid_nxt  = 1'b1;
      out_byte_nxt   = pend_r;
      out_last_nxt   = 1'b1;
      out_eos_nxt    = last_r;
      pend_valid_nxt = 1'b0;
    end
    if (cmd.clr_wr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      clr_addr_r   <= '0;
      probing_r    <= 1'b0;
      cp_r         <= 1'b0;
      eof_r        <= 1'b0;
      bc_r         <= '0;
      acc_r        <= '0;
      prefix_r     <= '0;
      nfc_r        <= 13'd258;
      width_r      <= 4'd9;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      probing_r    <= probing_nxt;
      cp_r         <= cp_nxt;
      eof_r        <= eof_nxt;
      bc_r         <= bc_nxt;
      acc_r        <= acc_nxt;
      prefix_r     <= prefix_nxt;
      nfc_r        <= nfc_nxt;
      width_r      <= width_nxt;
      if (cmd.clr_wr) begin
        clr_addr_r <= (clr_addr_r == HS - AW'(1)) ? '0 : clr_addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_r   <= in_tdata & px_mask;
      last_r <= in_tlast;
    end
    i_r        <= i_nxt;
    disp_r     <= disp_nxt;
    tries_r    <= tries_nxt;
    pend_r     <= pend_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_eos_r  <= out_eos_nxt;
  end

  glzw_ram #(
    .WIDTH (glzw_pkg::ENTRY_W),
    .DEPTH (glzw_pkg::HASH_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.hit        = s_valid && (s_key == key);
    sts.miss_end   = probing_r ?
                     (!(s_valid && s_key != '0) || tries_r == HS - AW'(1)) : !s_valid;
    sts.emit_more  = (bc_r >= 5'd8) || (eof_r && bc_r != 5'd0);
    sts.can_emit   = !pend_valid_r || out_free;
    sts.pend_valid = pend_valid_r;
    sts.nfc_full   = nfc_r >= 13'(glzw_pkg::CODE_LIMIT);
    sts.last       = last_r;
    sts.clr_last   = clr_addr_r == HS - AW'(1);
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_byte_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_eos_r;

endmodule

// ===== hdl/glzw_ctrl.sv =====
// Controller state machine that sequences lookup, code output and table clearing.
module glzw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output glzw_pkg::dp_cmd_t cmd,
  input  glzw_pkg::dp_sts_t sts
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_PROBE = 4'd3;
  localparam logic [3:0] S_PUTP  = 4'd4;
  localparam logic [3:0] S_MISS  = 4'd5;
  localparam logic [3:0] S_PUTC  = 4'd6;
  localparam logic [3:0] S_TAIL  = 4'd7;
  localparam logic [3:0] S_LASTP = 4'd8;
  localparam logic [3:0] S_LASTE = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;
  localparam logic [3:0] S_CLR   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [3:0] ret_r, ret_nxt;
  logic       first_r, first_nxt;
  logic       clr_req_r, clr_req_nxt;

  assign in_tready = state_r == S_IDLE;

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    first_nxt   = first_r;
    clr_req_nxt = clr_req_r;
    cmd         = '0;
    cmd.code_sel = glzw_pkg::CS_PREFIX;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (!first_r) begin
            cmd.start   = 1'b1;
            first_nxt   = 1'b1;
            clr_req_nxt = 1'b1;
            state_nxt   = S_PUTC;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.hash_rd = 1'b1;
        state_nxt   = S_CHK;
      end
      S_CHK: begin
        if (sts.hit) begin
          cmd.hit_take = 1'b1;
          state_nxt    = S_TAIL;
        end else if (sts.miss_end) begin
          state_nxt = S_PUTP;
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.probe_rd = 1'b1;
        state_nxt    = S_CHK;
      end
      S_PUTP: begin
        cmd.put   = 1'b1;
        ret_nxt   = S_MISS;
        state_nxt = S_EMIT;
      end
      S_MISS: begin
        cmd.miss_upd = 1'b1;
        if (sts.nfc_full) begin
          cmd.tbl_full = 1'b1;
          clr_req_nxt  = 1'b1;
          state_nxt    = S_PUTC;
        end else begin
          cmd.tbl_write = 1'b1;
          state_nxt     = S_TAIL;
        end
      end
      S_PUTC: begin
        cmd.put      = 1'b1;
        cmd.code_sel = glzw_pkg::CS_CLEAR;
        ret_nxt      = S_TAIL;
        state_nxt    = S_EMIT;
      end
      S_TAIL: begin
        state_nxt = sts.last ? S_LASTP : S_DONE;
      end
      S_LASTP: begin
        cmd.put   = 1'b1;
        ret_nxt   = S_LASTE;
        state_nxt = S_EMIT;
      end
      S_LASTE: begin
        cmd.put      = 1'b1;
        cmd.code_sel = glzw_pkg::CS_EOI;
        cmd.put_eof  = 1'b1;
        first_nxt    = 1'b0;
        ret_nxt      = S_DONE;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.emit_more) begin
          state_nxt = ret_r;
        end else if (sts.can_emit) begin
          cmd.emit = 1'b1;
        end
      end
      S_DONE: begin
        if (!sts.pend_valid || sts.can_emit) begin
          cmd.flush = sts.pend_valid;
          state_nxt = clr_req_r ? S_CLR : S_IDLE;
        end
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          clr_req_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ret_r     <= S_IDLE;
      first_r   <= 1'b0;
      clr_req_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ret_r     <= ret_nxt;
      first_r   <= first_nxt;
      clr_req_r <= clr_req_nxt;
    end
  end

endmodule

// ===== hdl/glzw_checker.sv =====
// Port-level assertions for the GIF LZW encoder and their binding to the top level.
module glzw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [0:0] out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word dropped while stalled");

  a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("end of stream byte without tlast");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind gif_lzw_encoder glzw_checker u_glzw_checker (.*);

// ===== sim/tb_gif_lzw_encoder.sv =====
// Self-checking testbench for the GIF LZW encoder: pixel stimulus, byte stream predictor and checks.
`timescale 1ns / 100ps

module tb_gif_lzw_encoder;

  localparam int HT_SIZE    = 5003;
  localparam int PX_SHIFT   = 4;
  localparam int MAXC       = 4096;
  localparam int MAX_BYTES  = 8;
  localparam int IDLE_LIMIT = 20000;
  localparam int CLEAR_WAIT = 5200;

  typedef struct {
    bit [7:0] data;
    bit       last;
    bit       eos;
  } stream_byte_t;

  class lzw_scoreboard;
    bit [20:0]    keys [HT_SIZE];
    bit [11:0]    codes [HT_SIZE];
    int unsigned  prefix, free_code, width, acc, nbits;
    bit           started, clear_due;
    bit [3:0]     min_size;
    stream_byte_t produced[$];
    stream_byte_t pending[$];
    int           fails;

    function new();
      min_size  = 4'd8;
      started   = 0;
      clear_due = 0;
      prefix    = 0;
      acc       = 0;
      nbits     = 0;
      fails     = 0;
      width     = 9;
      free_code = 258;
    endfunction

    function int unsigned clamped();
      int unsigned m;
      m = min_size;
      if (m < 2) m = 2;
      if (m > 8) m = 8;
      return m;
    endfunction

    function void wipe();
      for (int k = 0; k < HT_SIZE; k++) keys[k] = '0;
    endfunction

    function void shift_out();
      stream_byte_t sb;
      sb.data = acc[7:0];
      sb.last = 0;
      sb.eos  = 0;
      if (produced.size() < MAX_BYTES) produced.push_back(sb);
      acc = acc >> 8;
    endfunction

    function void put_code(int unsigned code, bit is_eof);
      int unsigned keep, maxcode;
      keep = (nbits < 24) ? ((1 << nbits) - 1) : 32'hFFFFFF;
      acc = ((acc & keep) | ((code & 12'hFFF) << (nbits & 15))) & 32'hFFFFFF;
      nbits += width;
      while (nbits >= 8) begin
        shift_out();
        nbits -= 8;
      end
      maxcode = (width >= 12) ? MAXC : ((1 << width) - 1);
      if (clear_due) begin
        width = clamped() + 1;
        clear_due = 0;
      end else if (free_code > maxcode && width < 12) begin
        width++;
      end
      if (is_eof) begin
        while (nbits > 0) begin
          shift_out();
          nbits = (nbits > 8) ? nbits - 8 : 0;
        end
      end
    endfunction

    function void note_pixel(bit [7:0] pixel, bit last);
      int unsigned m, cc, px, key, idx, disp, s;
      bit hit;
      m = clamped();
      cc = 1 << m;
      px = pixel & (cc - 1);
      produced.delete();
      if (!started) begin
        wipe();
        width = m + 1;
        free_code = cc + 2;
        clear_due = 0;
        acc = 0;
        nbits = 0;
        prefix = px;
        started = 1;
        put_code(cc, 0);
      end else begin
        key = ((px << 12) | (prefix & 12'hFFF)) & 20'hFFFFF;
        idx = ((px << PX_SHIFT) ^ (prefix & 12'hFFF)) % HT_SIZE;
        hit = 0;
        s = keys[idx];
        if (s[20] && s[19:0] == key) begin
          hit = 1;
        end else if (s[20]) begin
          disp = (idx == 0) ? 1 : HT_SIZE - idx;
          for (int t = 0; t < HT_SIZE; t++) begin
            idx = (idx >= disp) ? idx - disp : idx + HT_SIZE - disp;
            s = keys[idx];
            if (s[20] && s[19:0] == key) begin
              hit = 1;
              break;
            end
            if (!(s[20] && s[19:0] != 0)) break;
          end
        end
        if (hit) begin
          prefix = codes[idx];
        end else begin
          put_code(prefix, 0);
          prefix = px;
          if (free_code < MAXC) begin
            codes[idx] = free_code[11:0];
            keys[idx]  = {1'b1, key[19:0]};
            free_code++;
          end else begin
            wipe();
            free_code = cc + 2;
            clear_due = 1;
            put_code(cc, 0);
          end
        end
      end
      if (last) begin
        put_code(prefix, 0);
        put_code(cc + 1, 1);
        started = 0;
      end
      if (produced.size() > 0) begin
        produced[produced.size() - 1].last = 1;
        if (last) produced[produced.size() - 1].eos = 1;
      end
      foreach (produced[k]) pending.push_back(produced[k]);
    endfunction

    function void check_byte(bit [7:0] data, bit last, bit eos);
      stream_byte_t want;
      if (pending.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected byte %02h last=%0d eos=%0d", data, last, eos);
        return;
      end
      want = pending.pop_front();
      if (want.data != data || want.last != last || want.eos != eos) begin
        fails++;
        if (fails <= 10)
          $display("byte mismatch: expected %02h/%0d/%0d, got %02h/%0d/%0d",
                   want.data, want.last, want.eos, data, last, eos);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [0:0] out_tuser;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_data;

  lzw_scoreboard sb;
  int  idle_cycles;
  int  hold_len;
  bit  quiet;

  gif_lzw_encoder uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_byte(out_tdata, out_tlast, out_tuser[0]);
    if (rst_n && ((out_tvalid && out_tready) || (in_tvalid && in_tready))) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_gif_lzw_encoder: errors");
        $finish;
      end
    end
  end

  // The receiver takes words with random gaps and one long hold-off on request.
  initial begin
    int g;
    out_tready = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        out_tready <= 0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      g = quiet ? 0 : $urandom_range(0, 6);
      if (g > 0) begin
        out_tready <= 0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_pixel(bit [7:0] px, bit last);
    int g;
    g = quiet ? 0 : $urandom_range(0, 6);
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= px;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(px, last);
  endtask

  task automatic write_min_size(bit [3:0] v);
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (CLEAR_WAIT) @(posedge clk);
    cfg_valid <= 1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.min_size = v;
  endtask

  task automatic send_image(int len, int hi);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 4) == 0) send_pixel(8'($urandom_range(0, 255)), k == len - 1);
      else send_pixel(8'($urandom_range(0, hi)), k == len - 1);
    end
  endtask

  initial begin
    bit [3:0] sizes [7] = '{4'd2, 4'd0, 4'd15, 4'd5, 4'd3, 4'd7, 4'd8};
    int len;
    sb = new();
    idle_cycles = 0;
    hold_len = 0;
    quiet = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tlast = 0;
    cfg_valid = 0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // Directed images at the reset width: single pixel, a run of zeros, alternating extremes.
    send_pixel(8'd255, 1);
    for (int k = 0; k < 7; k++) send_pixel(8'd0, k == 6);
    send_pixel(8'd0, 0);   send_pixel(8'd255, 0); send_pixel(8'd0, 0);
    send_pixel(8'd255, 0); send_pixel(8'd170, 0); send_pixel(8'd85, 0);
    send_pixel(8'd170, 0); send_pixel(8'd85, 1);
    write_min_size(4'd2);
    send_pixel(8'd255, 0);
    for (int k = 0; k < 6; k++) send_pixel(8'(k % 3 + 1), k == 5);

    // Random images over several code sizes, with a long receiver hold-off in one of them.
    foreach (sizes[p]) begin
      write_min_size(sizes[p]);
      quiet = (p == 3);
      if (p == 1) hold_len = 400;
      for (int n = 0; n < 40; n += len) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        send_image(len, $urandom_range(1, 7));
      end
    end
    quiet = 0;

    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.fails == 0) $display("tb_gif_lzw_encoder: clean");
    else $display("tb_gif_lzw_encoder: errors");
    $finish;
  end
endmodule
